// ===== hw/rtl/sliding_window_median_assert.svh =====
// ============================================================================
// Sliding window median assertion macros
// Property templates that the port checker uses, all clocked on clk and
// disabled while rst_n is low.
// ============================================================================
`ifndef SLIDING_WINDOW_MEDIAN_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_ASSERT_SVH

// The consequent must hold in the cycle after the antecedent.
`define SWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define SWM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/swm_pkg.sv =====
// ============================================================================
// Sliding window median package
// Sizes, memory entry layout and sequencer states of the median filter.
// ============================================================================
package swm_pkg;

    // Sample values that the count tree covers, and the deepest window.
    localparam int VALUE_BITS = 16;
    localparam int WINDOW_MAX = 1024;
    localparam int TREE_SIZE  = 1 << VALUE_BITS;

    // Fixed port widths.
    localparam int SAMPLE_W = 16;
    localparam int MED_W    = 16;
    localparam int CFG_W    = 11;
    localparam int SUM_W    = 63;

    // Derived widths.
    localparam int K_W     = $clog2(WINDOW_MAX) + 1;
    localparam int PTR_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W   = K_W;
    localparam int WALK_W  = VALUE_BITS + 2;
    localparam int POS_W   = VALUE_BITS + 1;
    localparam int LVL_W   = $clog2(VALUE_BITS + 1);
    localparam int EPOCH_W = 16;

    // One node of the count tree: a count that only counts when its epoch
    // tag matches the current epoch.
    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [CNT_W-1:0]   count;
    } node_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_NEW,
        ST_ADD_OLD,
        ST_RANK_RD,
        ST_RANK_CHK,
        ST_DONE
    } state_t;

endpackage

// ===== hw/rtl/sliding_window_median.sv =====
// ============================================================================
// Sliding window median filter
// Each input transfer is worked through, with in_stall high, before the
// next input transfer is taken. Reset, and every 65536th restart, runs a
// clearing pass of the count memory with in_stall high.
// ============================================================================
module sliding_window_median (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [swm_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [swm_pkg::SAMPLE_W-1:0] sample,
    input  logic                         start_new,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [swm_pkg::MED_W-1:0]    median,
    output logic [swm_pkg::SUM_W-1:0]    running_sum
);

    // ------------------------------------------------------------------------
    // Overview
    //
    // The window is a ring of the last k samples in a small memory. The count
    // of each sample value lives in a binary indexed tree held in a large
    // single-read, single-write memory. Each accepted sample walks the tree
    // once to add itself and, once the window is full, once more to remove
    // the sample it replaces. When the window is full, the lower median is
    // found by a descent of the tree, one level per read. All tree traffic
    // goes through the one memory port pair under the sequencer below.
    //
    // Each update walk visits 1 to 17 nodes, writing back each node while
    // reading the next, and ends with the last write-back and the hand-over.
    // The descent reads and checks each of its 17 levels whose node lies in
    // the tree. ST_IDLE accepts the sample and ST_DONE posts the result.
    //
    // Restarts (start_new or a window_size write) do not clear the tree.
    // Instead each node carries an epoch tag and a restart advances the
    // epoch, so stale nodes read as zero. Only when the epoch would wrap is a
    // full clearing pass run, which also happens once after reset.
    // ------------------------------------------------------------------------

    swm_pkg::state_t state_reg, state_next;

    logic [swm_pkg::K_W-1:0]        k_reg, k_next;
    logic [swm_pkg::K_W-1:0]        fill_reg, fill_next;
    logic [swm_pkg::PTR_W-1:0]      ptr_reg, ptr_next;
    logic [swm_pkg::SUM_W-1:0]      sum_reg, sum_next;
    logic [swm_pkg::EPOCH_W-1:0]    epoch_reg, epoch_next;
    logic [swm_pkg::VALUE_BITS-1:0] clr_reg, clr_next;
    logic                           pend_reg, pend_next;
    logic                           has_old_reg, has_old_next;
    logic                           emit_reg, emit_next;
    logic [swm_pkg::WALK_W-1:0]     walk_reg, walk_next;
    logic                           wb_pend_reg, wb_pend_next;
    logic [swm_pkg::VALUE_BITS-1:0] wb_addr_reg, wb_addr_next;
    logic [swm_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [swm_pkg::LVL_W-1:0]      lvl_reg, lvl_next;
    logic [swm_pkg::CNT_W-1:0]      rem_reg, rem_next;
    logic                           out_valid_reg, out_valid_next;
    logic [swm_pkg::MED_W-1:0]      median_reg, median_next;
    logic [swm_pkg::SUM_W-1:0]      running_sum_reg, running_sum_next;

    // Window ring memory. One address serves the read and the write, and
    // the read returns the old contents.
    logic [swm_pkg::VALUE_BITS-1:0] win_mem [swm_pkg::WINDOW_MAX];
    logic                           win_we;
    logic                           win_re;
    logic [swm_pkg::PTR_W-1:0]      win_addr;
    logic [swm_pkg::VALUE_BITS-1:0] win_wdata;
    logic [swm_pkg::VALUE_BITS-1:0] win_rdata_reg;

    // Count tree memory. Node i of the tree lives at address i - 1.
    swm_pkg::node_t                 tree_mem [swm_pkg::TREE_SIZE];
    logic                           tree_we;
    logic [swm_pkg::VALUE_BITS-1:0] tree_waddr;
    swm_pkg::node_t                 tree_wdata;
    logic                           tree_re;
    logic [swm_pkg::VALUE_BITS-1:0] tree_raddr;
    swm_pkg::node_t                 tree_rdata_reg;

    logic                           in_xfer;
    logic                           out_free;
    logic [swm_pkg::CNT_W-1:0]      tree_cnt;
    logic [swm_pkg::K_W-1:0]        rank_val;
    logic [swm_pkg::K_W-1:0]        cfg_k;
    logic [swm_pkg::WALK_W-1:0]     walk_low;
    logic [swm_pkg::WALK_W-1:0]     desc_nxt;
    logic [swm_pkg::VALUE_BITS-1:0] med_val;
    logic [swm_pkg::K_W-1:0]        fill_base;
    logic [swm_pkg::PTR_W-1:0]      ptr_base;
    logic                           go_clear;

    assign in_stall    = (state_reg != swm_pkg::ST_IDLE);
    assign in_xfer     = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign out_valid   = out_valid_reg;
    assign median      = median_reg;
    assign running_sum = running_sum_reg;

    // A node written under an older epoch counts as empty.
    assign tree_cnt = (tree_rdata_reg.epoch == epoch_reg) ? tree_rdata_reg.count : '0;

    // Rank of the lower median, (k + 1) / 2.
    assign rank_val = swm_pkg::K_W'((32'(k_reg) + 32'd1) >> 1);

    // Window size as written, with zero taken as one and large values
    // saturated to the ring depth.
    always_comb
    begin
        if (32'(cfg_wr_data) > 32'(swm_pkg::WINDOW_MAX))
        begin
            cfg_k = swm_pkg::K_W'(swm_pkg::WINDOW_MAX);
        end
        else if (cfg_wr_data == '0)
        begin
            cfg_k = swm_pkg::K_W'(1);
        end
        else
        begin
            cfg_k = swm_pkg::K_W'(cfg_wr_data);
        end
    end

    // Lowest set bit of the tree index, the stride of an update walk.
    assign walk_low = walk_reg & (~walk_reg + swm_pkg::WALK_W'(1));

    // Node probed at the current level of the rank descent.
    assign desc_nxt = swm_pkg::WALK_W'(pos_reg) + (swm_pkg::WALK_W'(1) << lvl_reg);

    // The descent can run one past the last value; clamp it back.
    assign med_val = (32'(pos_reg) >= swm_pkg::TREE_SIZE)
                   ? swm_pkg::VALUE_BITS'(swm_pkg::TREE_SIZE - 1)
                   : swm_pkg::VALUE_BITS'(pos_reg);

    // Window position after an optional restart by start_new.
    assign fill_base = start_new ? '0 : fill_reg;
    assign ptr_base  = start_new ? '0 : ptr_reg;
    assign go_clear  = start_new && (epoch_reg == '1);

    // ------------------------------------------------------------------------
    // Sequencer and datapath next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        k_next           = k_reg;
        fill_next        = fill_reg;
        ptr_next         = ptr_reg;
        sum_next         = sum_reg;
        epoch_next       = epoch_reg;
        clr_next         = clr_reg;
        pend_next        = pend_reg;
        has_old_next     = has_old_reg;
        emit_next        = emit_reg;
        walk_next        = walk_reg;
        wb_pend_next     = wb_pend_reg;
        wb_addr_next     = wb_addr_reg;
        pos_next         = pos_reg;
        lvl_next         = lvl_reg;
        rem_next         = rem_reg;
        out_valid_next   = out_valid_reg;
        median_next      = median_reg;
        running_sum_next = running_sum_reg;

        win_we     = 1'b0;
        win_re     = 1'b0;
        win_addr   = ptr_reg;
        win_wdata  = walk_reg[swm_pkg::VALUE_BITS-1:0];
        tree_we    = 1'b0;
        tree_waddr = wb_addr_reg;
        tree_wdata = '0;
        tree_re    = 1'b0;
        tree_raddr = '0;

        // The output register empties on a completed transfer.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            swm_pkg::ST_CLEAR:
            begin
                // Write every node to zero under epoch zero.
                tree_we    = 1'b1;
                tree_waddr = clr_reg;
                tree_wdata = '0;
                clr_next   = clr_reg + 1'b1;
                if (32'(clr_reg) == swm_pkg::TREE_SIZE - 1)
                begin
                    state_next = pend_reg ? swm_pkg::ST_ADD_NEW : swm_pkg::ST_IDLE;
                    pend_next  = 1'b0;
                end
            end

            swm_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (start_new)
                    begin
                        sum_next   = '0;
                        epoch_next = go_clear ? '0 : epoch_reg + 1'b1;
                    end
                    walk_next = swm_pkg::WALK_W'(sample[swm_pkg::VALUE_BITS-1:0])
                              + swm_pkg::WALK_W'(1);
                    win_we       = 1'b1;
                    win_wdata    = sample[swm_pkg::VALUE_BITS-1:0];
                    wb_pend_next = 1'b0;
                    if (fill_base < k_reg)
                    begin
                        // Still filling: append at the fill position.
                        win_addr     = swm_pkg::PTR_W'(fill_base);
                        fill_next    = fill_base + 1'b1;
                        ptr_next     = ptr_base;
                        has_old_next = 1'b0;
                        emit_next    = ((fill_base + 1'b1) == k_reg);
                    end
                    else
                    begin
                        // Full: fetch the oldest sample and overwrite it.
                        win_addr     = ptr_base;
                        win_re       = 1'b1;
                        fill_next    = fill_base;
                        has_old_next = 1'b1;
                        emit_next    = 1'b1;
                        if ((swm_pkg::K_W'(ptr_base) + 1'b1) == k_reg)
                        begin
                            ptr_next = '0;
                        end
                        else
                        begin
                            ptr_next = ptr_base + 1'b1;
                        end
                    end
                    pend_next  = go_clear;
                    clr_next   = '0;
                    state_next = go_clear ? swm_pkg::ST_CLEAR : swm_pkg::ST_ADD_NEW;
                end
            end

            swm_pkg::ST_ADD_NEW,
            swm_pkg::ST_ADD_OLD:
            begin
                // Write back the node read last cycle, one up or one down.
                if (wb_pend_reg)
                begin
                    tree_we          = 1'b1;
                    tree_waddr       = wb_addr_reg;
                    tree_wdata.epoch = epoch_reg;
                    if (state_reg == swm_pkg::ST_ADD_NEW)
                    begin
                        tree_wdata.count = tree_cnt + 1'b1;
                    end
                    else
                    begin
                        tree_wdata.count = tree_cnt - 1'b1;
                    end
                end
                if (32'(walk_reg) <= swm_pkg::TREE_SIZE)
                begin
                    tree_re      = 1'b1;
                    tree_raddr   = swm_pkg::VALUE_BITS'(walk_reg - 1'b1);
                    wb_addr_next = swm_pkg::VALUE_BITS'(walk_reg - 1'b1);
                    wb_pend_next = 1'b1;
                    walk_next    = walk_reg + walk_low;
                end
                else
                begin
                    wb_pend_next = 1'b0;
                    if (!wb_pend_reg)
                    begin
                        if ((state_reg == swm_pkg::ST_ADD_NEW) && has_old_reg)
                        begin
                            walk_next  = swm_pkg::WALK_W'(win_rdata_reg) + swm_pkg::WALK_W'(1);
                            state_next = swm_pkg::ST_ADD_OLD;
                        end
                        else if (emit_reg)
                        begin
                            pos_next   = '0;
                            lvl_next   = swm_pkg::LVL_W'(swm_pkg::VALUE_BITS);
                            rem_next   = swm_pkg::CNT_W'(rank_val);
                            state_next = swm_pkg::ST_RANK_RD;
                        end
                        else
                        begin
                            state_next = swm_pkg::ST_IDLE;
                        end
                    end
                end
            end

            swm_pkg::ST_RANK_RD:
            begin
                if (32'(desc_nxt) <= swm_pkg::TREE_SIZE)
                begin
                    tree_re    = 1'b1;
                    tree_raddr = swm_pkg::VALUE_BITS'(desc_nxt - 1'b1);
                    state_next = swm_pkg::ST_RANK_CHK;
                end
                else if (lvl_reg == '0)
                begin
                    state_next = swm_pkg::ST_DONE;
                end
                else
                begin
                    lvl_next = lvl_reg - 1'b1;
                end
            end

            swm_pkg::ST_RANK_CHK:
            begin
                // Step right when the whole left span lies below the rank.
                if (tree_cnt < rem_reg)
                begin
                    pos_next = swm_pkg::POS_W'(desc_nxt);
                    rem_next = rem_reg - tree_cnt;
                end
                if (lvl_reg == '0)
                begin
                    state_next = swm_pkg::ST_DONE;
                end
                else
                begin
                    lvl_next   = lvl_reg - 1'b1;
                    state_next = swm_pkg::ST_RANK_RD;
                end
            end

            swm_pkg::ST_DONE:
            begin
                // Wait for room in the output register, then post the result.
                if (out_free)
                begin
                    sum_next         = sum_reg + swm_pkg::SUM_W'(med_val);
                    out_valid_next   = 1'b1;
                    median_next      = swm_pkg::MED_W'(med_val);
                    running_sum_next = sum_reg + swm_pkg::SUM_W'(med_val);
                    state_next       = swm_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = swm_pkg::ST_IDLE;
            end
        endcase

        // A window_size write restarts the window. During a clearing pass the
        // tree already ends up empty, so only the epoch is left alone there.
        if (cfg_wr_en)
        begin
            k_next    = cfg_k;
            fill_next = '0;
            ptr_next  = '0;
            sum_next  = '0;
            if (state_reg != swm_pkg::ST_CLEAR)
            begin
                if (epoch_reg == '1)
                begin
                    epoch_next = '0;
                    clr_next   = '0;
                    pend_next  = 1'b0;
                    state_next = swm_pkg::ST_CLEAR;
                end
                else
                begin
                    epoch_next = epoch_reg + 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // State register
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swm_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= swm_pkg::K_W'(1);
            fill_reg      <= '0;
            ptr_reg       <= '0;
            sum_reg       <= '0;
            epoch_reg     <= '0;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            wb_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg         <= k_next;
            fill_reg      <= fill_next;
            ptr_reg       <= ptr_next;
            sum_reg       <= sum_next;
            epoch_reg     <= epoch_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            wb_pend_reg   <= wb_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        has_old_reg     <= has_old_next;
        emit_reg        <= emit_next;
        walk_reg        <= walk_next;
        wb_addr_reg     <= wb_addr_next;
        pos_reg         <= pos_next;
        lvl_reg         <= lvl_next;
        rem_reg         <= rem_next;
        median_reg      <= median_next;
        running_sum_reg <= running_sum_next;
    end

    // ------------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (win_re)
        begin
            win_rdata_reg <= win_mem[win_addr];
        end
        if (win_we)
        begin
            win_mem[win_addr] <= win_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tree_re)
        begin
            tree_rdata_reg <= tree_mem[tree_raddr];
        end
        if (tree_we)
        begin
            tree_mem[tree_waddr] <= tree_wdata;
        end
    end

endmodule

// ===== hw/rtl/swm_checker.sv =====
// ============================================================================
// Sliding window median port checker
// Watches the top-level ports for handshake and sequencing errors.
// ============================================================================
`include "sliding_window_median_assert.svh"

module swm_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cfg_wr_en,
    input logic [swm_pkg::CFG_W-1:0]    cfg_wr_data,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic [swm_pkg::SAMPLE_W-1:0] sample,
    input logic                         start_new,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [swm_pkg::MED_W-1:0]    median,
    input logic [swm_pkg::SUM_W-1:0]    running_sum
);

    // A stalled result stays offered.
    `SWM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

    // A stalled result keeps its value.
    `SWM_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(median) && $stable(running_sum), "result changed while stalled")

    // Every input transfer keeps the block busy for at least the next cycle.
    `SWM_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall, "input taken on consecutive cycles")

    // A new result only comes out of work in progress.
    `SWM_ASSERT_SAME(a_result_from_work, $rose(out_valid), $past(in_stall), "result appeared while idle")

endmodule

bind sliding_window_median swm_checker u_swm_checker (.*);

// ===== bench/swm_median_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window median checker
// Watches the configuration port and both transfer channels of the median
// filter, predicts each median and running sum, and compares every result.
// ----------------------------------------------------------------------------
module swm_median_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [swm_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [swm_pkg::SAMPLE_W-1:0] sample,
    input  logic                         start_new,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [swm_pkg::MED_W-1:0]    median,
    input  logic [swm_pkg::SUM_W-1:0]    running_sum,
    output int                           fail_count,
    output int                           medians_due,
    output int                           medians_checked
);

    typedef struct packed {
        logic [swm_pkg::MED_W-1:0] median;
        logic [swm_pkg::SUM_W-1:0] running_sum;
    } median_result_t;

    logic [swm_pkg::CFG_W-1:0]    window_reg;
    logic [swm_pkg::SAMPLE_W-1:0] arrival_q[$];
    logic [swm_pkg::SAMPLE_W-1:0] sorted_q[$];
    logic [63:0]                  median_total;
    median_result_t               median_due_q[$];

    // A zero size acts as one sample, and sizes past the deepest window saturate.
    function automatic int window_depth();
        if (window_reg == '0)
        begin
            return 1;
        end
        if (window_reg > swm_pkg::WINDOW_MAX)
        begin
            return swm_pkg::WINDOW_MAX;
        end
        return int'(window_reg);
    endfunction

    function automatic void clear_window();
        arrival_q.delete();
        sorted_q.delete();
        median_total = '0;
    endfunction

    // Arrival order gives the sample to drop; the sorted copy gives the rank.
    function automatic void slide_window(logic [swm_pkg::SAMPLE_W-1:0] value,
                                         logic clear_first);
        int                           depth;
        int                           pos;
        logic [swm_pkg::SAMPLE_W-1:0] oldest;
        logic [swm_pkg::MED_W-1:0]    med;
        median_result_t               res;
        depth = window_depth();
        if (clear_first)
        begin
            clear_window();
        end
        if (arrival_q.size() >= depth)
        begin
            oldest = arrival_q.pop_front();
            pos = 0;
            while (sorted_q[pos] != oldest)
            begin
                pos++;
            end
            sorted_q.delete(pos);
        end
        pos = 0;
        while (pos < sorted_q.size() && sorted_q[pos] < value)
        begin
            pos++;
        end
        sorted_q.insert(pos, value);
        arrival_q.insert(arrival_q.size(), value);
        if (arrival_q.size() == depth)
        begin
            med = sorted_q[(depth + 1) / 2 - 1];
            median_total += 64'(med);
            res.median = med;
            res.running_sum = median_total[swm_pkg::SUM_W-1:0];
            median_due_q.insert(median_due_q.size(), res);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        median_result_t want;
        if (!rst_n)
        begin
            window_reg = swm_pkg::CFG_W'(1);
            clear_window();
            median_due_q.delete();
            fail_count = 0;
            medians_checked = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (median_due_q.size() == 0)
                begin
                    $error("unexpected result: median %0d, running_sum %0d",
                           median, running_sum);
                    fail_count++;
                end
                else
                begin
                    want = median_due_q.pop_front();
                    medians_checked++;
                    if (median !== want.median)
                    begin
                        $error("median: expected %0d, actual %0d", want.median, median);
                        fail_count++;
                    end
                    if (running_sum !== want.running_sum)
                    begin
                        $error("running_sum: expected %0d, actual %0d",
                               want.running_sum, running_sum);
                        fail_count++;
                    end
                end
            end
            // A size write restarts the window just like start_new does.
            if (cfg_wr_en)
            begin
                window_reg = cfg_wr_data;
                clear_window();
            end
            if (in_valid && !in_stall)
            begin
                slide_window(sample, start_new);
            end
        end
        medians_due = median_due_q.size();
    end

endmodule

// ===== bench/tb_sliding_window_median.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window median testbench
// Drives samples into the median filter under several window sizes and
// handshake idling patterns; a separate checker predicts and compares every
// median and running sum, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_sliding_window_median;

    localparam int HALF_PERIOD_NS   = 4;
    localparam int RESET_CYCLES     = 6;
    // A sample that only fills the window produces nothing we could wait on.
    localparam int SETTLE_CYCLES    = 100;
    localparam int SEND_IDLE_PCT    = 49;
    localparam int RECV_STALL_PCT   = 49;
    localparam int BOTH_IDLE_PCT    = 25;
    localparam int HOLD_CYCLES      = 600;
    localparam int BIG_WINDOW_ITEMS = 1040;
    // Longest correct quiet stretch is the clearing pass after reset; the
    // limit sits well above it before calling the run hung.
    localparam int QUIET_LIMIT      = 270000;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    logic                         clk         = 1'b0;
    logic                         rst_n       = 1'b0;
    logic                         cfg_wr_en   = 1'b0;
    logic [swm_pkg::CFG_W-1:0]    cfg_wr_data = '0;
    logic                         in_valid    = 1'b0;
    logic [swm_pkg::SAMPLE_W-1:0] sample      = '0;
    logic                         start_new   = 1'b0;
    logic                         out_stall   = 1'b0;
    logic                         in_stall;
    logic                         out_valid;
    logic [swm_pkg::MED_W-1:0]    median;
    logic [swm_pkg::SUM_W-1:0]    running_sum;

    int         fail_count;
    int         medians_due;
    int         medians_checked;
    int         transfers_sent = 0;
    int         settings_used  = 0;
    int         quiet_cycles   = 0;
    idle_mode_t idle_mode      = IDLE_NONE;
    // Set by the stimulus to ask the receiver for one long hold-off.
    logic       hold_req       = 1'b0;

    always #(HALF_PERIOD_NS) clk = ~clk;

    sliding_window_median dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .start_new   (start_new),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .median      (median),
        .running_sum (running_sum)
    );

    swm_median_checker u_median_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .sample          (sample),
        .start_new       (start_new),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .median          (median),
        .running_sum     (running_sum),
        .fail_count      (fail_count),
        .medians_due     (medians_due),
        .medians_checked (medians_checked)
    );

    // Receiver side. Stall decisions are made at the falling edge so that they
    // are stable at the next rising edge. A hold-off request keeps the stall
    // high for a long stretch, which backs the block up until it stalls its
    // own input while the sender keeps offering samples.
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            out_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
        end
        else
        begin
            case (idle_mode)
                IDLE_RECV: out_stall <= ($urandom_range(99) < RECV_STALL_PCT);
                IDLE_BOTH: out_stall <= ($urandom_range(99) < BOTH_IDLE_PCT);
                default:   out_stall <= 1'b0;
            endcase
        end
    end

    // Watchdog: any transfer or register write counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles.", QUIET_LIMIT);
            $display("tb_sliding_window_median: done, errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Mixes the full value range with tight clusters, so that ties and both
    // extremes show up often inside one window.
    function automatic logic [swm_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(3))
            0:       return swm_pkg::SAMPLE_W'($urandom_range(65535));
            1:       return swm_pkg::SAMPLE_W'($urandom_range(7));
            2:       return swm_pkg::SAMPLE_W'(16'hFFFF - $urandom_range(3));
            default: return swm_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    // Offers one sample and returns at the falling edge after its transfer.
    // Valid stays high on return; the caller either offers the next sample at
    // this edge or lowers valid, never both.
    task automatic send_sample(input logic [swm_pkg::SAMPLE_W-1:0] value,
                               input logic restart);
        while ((idle_mode == IDLE_SEND && $urandom_range(99) < SEND_IDLE_PCT) ||
               (idle_mode == IDLE_BOTH && $urandom_range(99) < BOTH_IDLE_PCT))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        sample    <= value;
        start_new <= restart;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        transfers_sent++;
        @(negedge clk);
    endtask

    // Changes the window only once the block has gone quiet: every expected
    // result has arrived, and any sample still being folded in has had time
    // to finish even though it produces no result.
    task automatic write_window(input logic [swm_pkg::CFG_W-1:0] size);
        in_valid <= 1'b0;
        while (medians_due != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= size;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic send_random(input int count, input int restart_pct);
        for (int n = 0; n < count; n++)
        begin
            send_sample(pick_sample(), $urandom_range(99) < restart_pct);
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, three-sample window: extremes, ties, and a restart on
        // the first sample, in the middle of filling, and on a full window.
        write_window(swm_pkg::CFG_W'(3));
        send_sample(16'd0,     1'b1);
        send_sample(16'hFFFF,  1'b0);
        send_sample(16'hFFFF,  1'b0);
        send_sample(16'd1,     1'b0);
        send_sample(16'd0,     1'b0);
        send_sample(16'h8000,  1'b0);
        send_sample(16'd7,     1'b1);
        send_sample(16'd9,     1'b0);
        send_sample(16'hFFFE,  1'b1);
        send_sample(16'd0,     1'b0);
        send_sample(16'd0,     1'b0);
        send_sample(16'hFFFF,  1'b1);
        send_sample(16'hFFFF,  1'b0);
        send_sample(16'hFFFF,  1'b0);
        send_sample(16'h5555,  1'b0);
        send_sample(16'hAAAA,  1'b0);

        // An even window takes the lower of the two middle values.
        write_window(swm_pkg::CFG_W'(2));
        send_sample(16'd300,   1'b0);
        send_sample(16'd200,   1'b0);
        send_sample(16'd100,   1'b0);
        send_sample(16'hFFFF,  1'b0);

        // Left half full on purpose: the next size write must discard it.
        write_window(swm_pkg::CFG_W'(4));
        send_sample(16'd5,     1'b0);
        send_sample(16'd6,     1'b0);

        // A zero size behaves as a one-sample window.
        write_window(swm_pkg::CFG_W'(0));
        idle_mode = IDLE_SEND;
        send_random(30, 5);

        // Odd window with the long receiver hold-off while samples keep coming.
        write_window(swm_pkg::CFG_W'(5));
        idle_mode = IDLE_NONE;
        hold_req  = 1'b1;
        send_random(50, 2);

        write_window(swm_pkg::CFG_W'(2));
        idle_mode = IDLE_RECV;
        send_random(30, 3);

        write_window(swm_pkg::CFG_W'(16));
        idle_mode = IDLE_BOTH;
        send_random(50, 2);

        write_window(swm_pkg::CFG_W'(1));
        idle_mode = IDLE_NONE;
        send_random(20, 10);

        // All ones saturates to the deepest window; enough samples go in to
        // fill it and then wrap the delay line. The idling pattern rotates so
        // every style of gap lands on this phase too.
        write_window(swm_pkg::CFG_W'(2047));
        for (int n = 0; n < BIG_WINDOW_ITEMS; n++)
        begin
            idle_mode = idle_mode_t'((n / 128) % 4);
            send_sample(pick_sample(), 1'b0);
        end

        write_window(swm_pkg::CFG_W'(7));
        idle_mode = IDLE_BOTH;
        send_random(30, 4);

        // Drain: wait for every predicted result, then watch a while longer
        // for anything the block should not have produced.
        in_valid <= 1'b0;
        idle_mode = IDLE_NONE;
        while (medians_due != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Covered %0d sample transfers over %0d window sizes, zero to saturated.",
                 transfers_sent, settings_used);
        $display("Compared %0d medians with their running sums under mixed idling.",
                 medians_checked);
        if (fail_count == 0)
        begin
            $display("tb_sliding_window_median: done, clean");
        end
        else
        begin
            $display("tb_sliding_window_median: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/swm_pkg.sv
hw/rtl/sliding_window_median.sv
hw/rtl/swm_checker.sv
bench/swm_median_checker.sv
bench/tb_sliding_window_median.sv
